// ===== rtl/mbx_pkg.sv =====
// Shared types and constants for the multi-slot byte mailbox.
// No dependencies; imported by the front, back and top-level modules.
`default_nettype none

package mbx_pkg;

    // Fixed port widths
    localparam int KIND_W   = 3;
    localparam int KEY_W    = 64;
    localparam int SLOT_W_P = 3;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;

    // Default sizes
    localparam int SLOT_COUNT_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int KEY_BITS_DEF    = 64;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    // Request kinds; KIND_BAD marks anything the back end just rejects
    localparam t_kind KIND_CREATE = 3'd0;
    localparam t_kind KIND_OPEN   = 3'd1;
    localparam t_kind KIND_REMOVE = 3'd2;
    localparam t_kind KIND_WRITE  = 3'd3;
    localparam t_kind KIND_READ   = 3'd4;
    localparam t_kind KIND_BAD    = 3'd7;

    localparam t_status STAT_OK        = 3'd0;
    localparam t_status STAT_NOT_FOUND = 3'd1;
    localparam t_status STAT_FULL      = 3'd2;
    localparam t_status STAT_BAD_DESC  = 3'd3;
    localparam t_status STAT_EOF       = 3'd4;
    localparam t_status STAT_OVERFLOW  = 3'd5;

    // Classified item handed from front to back
    typedef struct packed {
        t_kind               op;
        logic [KEY_W-1:0]    name_key;
        logic [SLOT_W_P-1:0] slot;
        logic [BYTE_W-1:0]   data_byte;
        logic                final_byte;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/multi_slot_byte_mailbox_core.sv =====
// Result strobe: o_done is registered; an item passes the front queue, then the back end's
//   IDLE and EXEC states, plus RDATA for a read that pops a byte from the registered store.
// The back end takes a new item only after it is through with the last one, back in IDLE.
// A two-entry item queue lets start be taken while the back end works.
// Reset is synchronous and clears the slot table and all ring pointers at once.
// Top level of the mailbox; depends on mbx_pkg, mbx_front, mbx_back (mbx_ram).
`default_nettype none

module multi_slot_byte_mailbox_core
    import mbx_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [KEY_W-1:0]    i_name_key,
    input  wire logic [SLOT_W_P-1:0] i_slot,
    input  wire logic [BYTE_W-1:0]   i_data_byte,
    input  wire logic                i_final_byte,
    output logic                     o_done,
    output logic [STATUS_W-1:0]      o_status,
    output logic [SLOT_W_P-1:0]      o_slot_res,
    output logic [BYTE_W-1:0]        o_data_byte_res,
    output logic                     o_final_res
);

    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    mbx_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_name_key   (i_name_key),
        .i_slot       (i_slot),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_valid      (q_valid),
        .o_cmd        (q_cmd),
        .i_pop        (q_pop)
    );

    mbx_back #(
        .SLOT_COUNT  (SLOT_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (q_pop),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_slot_res      (o_slot_res),
        .o_data_byte_res (o_data_byte_res),
        .o_final_res     (o_final_res)
    );

endmodule

`default_nettype wire

// ===== rtl/mbx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mbx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mbx_front.sv =====
// Front end: takes items, classifies them, holds them in a two-entry queue.
// Depends on mbx_pkg.
`default_nettype none

module mbx_front
    import mbx_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [KEY_W-1:0]    i_name_key,
    input  wire logic [SLOT_W_P-1:0] i_slot,
    input  wire logic [BYTE_W-1:0]   i_data_byte,
    input  wire logic                i_final_byte,
    output logic                     o_valid,
    output t_cmd                     o_cmd,
    input  wire logic                i_pop
);

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       push;
    logic       slot_ok;

    assign busy    = (r_cnt == 2'd2);
    assign push    = start && !busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];
    assign slot_ok = (32'(i_slot) < 32'(SLOT_COUNT));

    always_comb begin
        n_cmd.name_key   = i_name_key;
        n_cmd.slot       = i_slot;
        n_cmd.data_byte  = i_data_byte;
        n_cmd.final_byte = i_final_byte;
        unique case (i_kind)
            KIND_CREATE, KIND_OPEN, KIND_REMOVE: n_cmd.op = i_kind;
            KIND_WRITE, KIND_READ:               n_cmd.op = slot_ok ? i_kind : KIND_BAD;
            default:                             n_cmd.op = KIND_BAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != 2'd0))
        else $error("pop from empty item queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("item queue count out of range");
    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("item queue count lost a push");
`endif

endmodule

`default_nettype wire

// ===== rtl/mbx_back.sv =====
// Back end: slot table, per-slot ring pointers and the byte store; runs one
// item at a time and drives the result registers. Depends on mbx_pkg, mbx_ram.
`default_nettype none

module mbx_back
    import mbx_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire t_cmd                i_cmd,
    output logic                     o_pop,
    output logic                     o_done,
    output logic [STATUS_W-1:0]      o_status,
    output logic [SLOT_W_P-1:0]      o_slot_res,
    output logic [BYTE_W-1:0]        o_data_byte_res,
    output logic                     o_final_res
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(SLOT_COUNT * QUEUE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_RDATA = 2'd2;

    logic [1:0]            r_state, n_state;
    t_cmd                  r_cmd;
    logic [SLOT_COUNT-1:0] r_match;
    logic [SLOT_COUNT-1:0] r_used, n_used;
    logic [KEY_BITS-1:0]   r_name [SLOT_COUNT];
    logic [PTR_W-1:0]      r_head [SLOT_COUNT];
    logic [PTR_W-1:0]      r_tail [SLOT_COUNT];
    logic [CNT_W-1:0]      r_cnt  [SLOT_COUNT];
    logic [PTR_W-1:0]      n_head [SLOT_COUNT];
    logic [PTR_W-1:0]      n_tail [SLOT_COUNT];
    logic [CNT_W-1:0]      n_cnt  [SLOT_COUNT];

    logic                  free_hit, match_hit;
    logic [SLOT_W-1:0]     lowest_free, match_idx, sidx;
    logic                  name_we;
    logic                  n_done;
    t_status               n_status;
    logic [SLOT_W_P-1:0]   n_slot_res;
    logic [BYTE_W-1:0]     n_data;
    logic                  ram_we, ram_re;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr, slot_base;
    logic [BYTE_W-1:0]     ram_rdata;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign sidx      = SLOT_W'(r_cmd.slot);
    assign slot_base = ADDR_W'(sidx) * ADDR_W'(QUEUE_DEPTH);
    assign ram_waddr = slot_base + ADDR_W'(r_tail[sidx]);
    assign ram_raddr = slot_base + ADDR_W'(r_head[sidx]);
    assign o_pop     = (r_state == S_IDLE) && i_valid;

    // lowest free slot and lowest matching used slot
    always_comb begin
        free_hit    = 1'b0;
        lowest_free = '0;
        match_hit   = 1'b0;
        match_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_hit    = 1'b1;
                lowest_free = SLOT_W'(i);
            end
            if (r_match[i]) begin
                match_hit = 1'b1;
                match_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_head     = r_head;
        n_tail     = r_tail;
        n_cnt      = r_cnt;
        name_we    = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        n_done     = 1'b0;
        n_status   = STAT_OK;
        n_slot_res = r_cmd.slot;
        n_data     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                unique case (r_cmd.op)
                    KIND_CREATE: begin
                        if (free_hit) begin
                            n_used[lowest_free] = 1'b1;
                            n_head[lowest_free] = '0;
                            n_tail[lowest_free] = '0;
                            n_cnt[lowest_free]  = '0;
                            name_we             = 1'b1;
                            n_slot_res          = SLOT_W_P'(lowest_free);
                        end else begin
                            n_status = STAT_FULL;
                        end
                    end
                    KIND_OPEN: begin
                        if (match_hit) begin
                            n_slot_res = SLOT_W_P'(match_idx);
                        end else begin
                            n_status = STAT_NOT_FOUND;
                        end
                    end
                    KIND_REMOVE: begin
                        if (match_hit) begin
                            n_used[match_idx] = 1'b0;
                        end else begin
                            n_status = STAT_NOT_FOUND;
                        end
                    end
                    KIND_WRITE: begin
                        if (!r_used[sidx]) begin
                            n_status = STAT_BAD_DESC;
                        end else if (r_cnt[sidx] == CNT_W'(QUEUE_DEPTH)) begin
                            n_status = STAT_OVERFLOW;
                        end else begin
                            ram_we       = 1'b1;
                            n_tail[sidx] = ring_next(r_tail[sidx]);
                            n_cnt[sidx]  = r_cnt[sidx] + CNT_W'(1);
                        end
                    end
                    KIND_READ: begin
                        if (!r_used[sidx]) begin
                            n_status = STAT_BAD_DESC;
                        end else if (r_cnt[sidx] == '0) begin
                            n_status = STAT_EOF;
                        end else begin
                            // byte comes back from the store next cycle
                            ram_re       = 1'b1;
                            n_head[sidx] = ring_next(r_head[sidx]);
                            n_cnt[sidx]  = r_cnt[sidx] - CNT_W'(1);
                            n_done       = 1'b0;
                            n_state      = S_RDATA;
                        end
                    end
                    default: begin
                        n_status = STAT_BAD_DESC;
                    end
                endcase
            end
            S_RDATA: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                n_data  = ram_rdata;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            o_done  <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
            o_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_match[i] <= r_used[i] && (r_name[i] == KEY_BITS'(i_cmd.name_key));
            end
        end
        if (name_we) begin
            r_name[lowest_free] <= KEY_BITS'(r_cmd.name_key);
        end
        o_status        <= n_status;
        o_slot_res      <= n_slot_res;
        o_data_byte_res <= n_data;
        o_final_res     <= r_cmd.final_byte;
    end

    mbx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SLOT_COUNT * QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_cmd.data_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

`ifndef NO_ASSERTIONS
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results in consecutive cycles");
    a_create_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_cmd.op == KIND_CREATE && free_hit)
            |=> r_used[$past(lowest_free)])
        else $error("created slot not marked used");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && (r_cmd.op == KIND_WRITE || r_cmd.op == KIND_READ))
            |-> (r_cnt[sidx] <= CNT_W'(QUEUE_DEPTH)))
        else $error("queue count above depth");
`endif

endmodule

`default_nettype wire
